@@ hdl/fhlp_pkg.sv @@
// shared types and constants for the framed hold list parser
package fhlp_pkg;

  localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_DATA = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  localparam logic [1:0] CLS_START  = 2'd0;
  localparam logic [1:0] CLS_MOVE   = 2'd1;
  localparam logic [1:0] CLS_FINISH = 2'd2;

  localparam logic KIND_HOLD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // what one input byte leaves for the back end to send
  typedef struct packed {
    logic       has_hold;
    logic [1:0] hold_class;
    logic [7:0] hold_number;
    logic       has_status;
    logic [1:0] chunk_status;
  } fhlp_entry_t;

  typedef struct packed {
    logic        valid;
    fhlp_entry_t entry;
  } fhlp_push_t;

  typedef struct packed {
    logic        not_empty;
    logic        full;
    fhlp_entry_t entry;
  } fhlp_head_t;

endpackage

@@ hdl/fhlp_in_if.sv @@
// input byte channel of the hold list parser
interface fhlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_first;
  logic       chunk_last;
  logic       empty_chunk;

  modport source (output valid, data_byte, chunk_first, chunk_last, empty_chunk,
                  input ready);
  modport sink (input valid, data_byte, chunk_first, chunk_last, empty_chunk,
                output ready);
endinterface

@@ hdl/fhlp_out_if.sv @@
// result channel of the hold list parser
interface fhlp_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] hold_class;
  logic [7:0] hold_number;
  logic [1:0] chunk_status;
  logic       last_of_item;

  modport source (output valid, result_kind, hold_class, hold_number, chunk_status,
                  last_of_item, input ready);
  modport sink (input valid, result_kind, hold_class, hold_number, chunk_status,
                last_of_item, output ready);
endinterface

@@ hdl/fhlp_front.sv @@
// front end: framing and field parsing, one byte per cycle while accept is high
module fhlp_front import fhlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        chunk_first,
  input  logic        chunk_last,
  input  logic        empty_chunk,
  output fhlp_push_t  push
);

  logic [1:0] frame_state_r, frame_state_nxt;
  logic       start_phase_r, start_phase_nxt;
  logic [1:0] class_r, class_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic       stopped_r, stopped_nxt;
  logic       is_digit;
  logic [7:0] digit_val;

  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit_val = data_byte - CH_ZERO;

  always_comb begin
    frame_state_nxt = frame_state_r;
    start_phase_nxt = start_phase_r;
    class_nxt       = class_r;
    acc_nxt         = acc_r;
    stopped_nxt     = stopped_r;
    push            = '0;

    if (empty_chunk) begin
      frame_state_nxt               = ST_WAIT;
      start_phase_nxt               = 1'b0;
      class_nxt                     = CLS_START;
      acc_nxt                       = '0;
      stopped_nxt                   = 1'b0;
      push.entry.has_status         = 1'b1;
      push.entry.chunk_status       = ST_ERR;
    end else begin
      if (chunk_first && frame_state_r == ST_DONE) begin
        frame_state_nxt = ST_WAIT;
        start_phase_nxt = 1'b0;
        class_nxt       = CLS_START;
        acc_nxt         = '0;
        stopped_nxt     = 1'b0;
      end

      if (frame_state_nxt == ST_WAIT) begin
        if (chunk_first) begin
          start_phase_nxt = (data_byte == CH_L) && !chunk_last;
        end else if (start_phase_nxt) begin
          start_phase_nxt = 1'b0;
          if (data_byte == CH_HASH) begin
            class_nxt       = CLS_START;
            acc_nxt         = '0;
            stopped_nxt     = 1'b0;
            frame_state_nxt = ST_DATA;
          end
        end
      end else if (frame_state_nxt == ST_DATA) begin
        if (chunk_last && data_byte == CH_HASH) begin
          push.entry.has_hold    = 1'b1;
          push.entry.hold_class  = class_nxt;
          push.entry.hold_number = acc_nxt;
          frame_state_nxt        = ST_DONE;
          start_phase_nxt        = 1'b0;
          class_nxt              = CLS_START;
          acc_nxt                = '0;
          stopped_nxt            = 1'b0;
        end else if (data_byte == CH_S) begin
          class_nxt = CLS_START;
        end else if (data_byte == CH_P) begin
          class_nxt = CLS_MOVE;
        end else if (data_byte == CH_E) begin
          class_nxt = CLS_FINISH;
        end else if (data_byte == CH_COMMA) begin
          push.entry.has_hold    = 1'b1;
          push.entry.hold_class  = class_nxt;
          push.entry.hold_number = acc_nxt;
          acc_nxt                = '0;
          stopped_nxt            = 1'b0;
        end else if (!stopped_nxt && is_digit) begin
          // times ten as two shifts, wraps at eight bits
          acc_nxt = (acc_nxt << 3) + (acc_nxt << 1) + digit_val;
        end else begin
          stopped_nxt = 1'b1;
        end
      end

      push.entry.has_status   = chunk_last;
      push.entry.chunk_status = chunk_last ? frame_state_nxt : ST_WAIT;
    end

    push.valid = accept && (push.entry.has_hold || push.entry.has_status);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_state_r <= ST_WAIT;
      start_phase_r <= 1'b0;
      class_r       <= CLS_START;
      acc_r         <= '0;
      stopped_r     <= 1'b0;
    end else if (accept) begin
      frame_state_r <= frame_state_nxt;
      start_phase_r <= start_phase_nxt;
      class_r       <= class_nxt;
      acc_r         <= acc_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

@@ hdl/fhlp_queue.sv @@
// short queue of pending result requests between front and back
module fhlp_queue import fhlp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  fhlp_push_t push,
  input  logic       pop,
  output fhlp_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  fhlp_entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign head.not_empty = (count_r != '0);
  assign head.full      = (count_r == FULL_CNT);
  assign head.entry     = slot_r[rd_ptr_r];

  assign do_push = push.valid && !head.full;
  assign do_pop  = pop && head.not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

@@ hdl/fhlp_back.sv @@
// back end: splits each queued request into results and drives the output register
module fhlp_back import fhlp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  fhlp_head_t          head,
  output logic                pop,
  fhlp_out_if.source          out_chan
);

  logic       hold_sent_r, hold_sent_nxt;
  logic       valid_r, valid_nxt;
  logic       kind_r, kind_nxt;
  logic [1:0] class_r, class_nxt;
  logic [7:0] number_r, number_nxt;
  logic [1:0] status_r, status_nxt;
  logic       last_r, last_nxt;
  logic       load;

  // output register refills when empty or being taken
  assign load = !valid_r || out_chan.ready;

  always_comb begin
    hold_sent_nxt = hold_sent_r;
    valid_nxt     = valid_r;
    kind_nxt      = kind_r;
    class_nxt     = class_r;
    number_nxt    = number_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = head.not_empty;
      if (head.not_empty) begin
        if (head.entry.has_hold && !hold_sent_r) begin
          kind_nxt   = KIND_HOLD;
          class_nxt  = head.entry.hold_class;
          number_nxt = head.entry.hold_number;
          status_nxt = ST_WAIT;
          last_nxt   = !head.entry.has_status;
          if (head.entry.has_status) begin
            hold_sent_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          kind_nxt      = KIND_STATUS;
          class_nxt     = CLS_START;
          number_nxt    = '0;
          status_nxt    = head.entry.chunk_status;
          last_nxt      = 1'b1;
          hold_sent_nxt = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      hold_sent_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      hold_sent_r <= hold_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    class_r  <= class_nxt;
    number_r <= number_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.result_kind  = kind_r;
  assign out_chan.hold_class   = class_r;
  assign out_chan.hold_number  = number_r;
  assign out_chan.chunk_status = status_r;
  assign out_chan.last_of_item = last_r;

endmodule

@@ hdl/framed_hold_list_parser.sv @@
// Framed hold list parser, top level.
// in_chan takes one message byte per request with its chunk-first, chunk-last
// and empty-chunk flags. out_chan gives parsed holds (class and 8-bit number)
// and a chunk status after every chunk end; last_of_item marks the final
// result caused by one byte, and a byte may cause zero, one or two results.
// The front end parses one byte per cycle and hands its results, if any, to
// a small queue of QUEUE_DEPTH entries; the back end sends one result per
// cycle from the queue through the output register.
// A byte's results go from the queue into the output register; the
// second result of a byte is loaded as the first is taken.
// Throughput: one byte per cycle while the queue has room; sustained output
// is one result per cycle while out_chan is ready, and a byte with both a
// hold and a status stays at the queue head until both are sent.
// A stall on out_chan fills the queue, and in_ready drops only when it is
// full. Synchronous reset (rst_n low) empties the queue and the output
// register and returns the parser to waiting for a message start.
module framed_hold_list_parser import fhlp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  fhlp_in_if.sink     in_chan,
  fhlp_out_if.source  out_chan
);

  fhlp_push_t push;
  fhlp_head_t head;
  logic       pop;
  logic       accept;

  assign in_chan.ready = !head.full;
  assign accept        = in_chan.valid && !head.full;

  fhlp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_chan.data_byte),
    .chunk_first (in_chan.chunk_first),
    .chunk_last  (in_chan.chunk_last),
    .empty_chunk (in_chan.empty_chunk),
    .push        (push)
  );

  fhlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head)
  );

  fhlp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

@@ bench/fhlp_checker.sv @@
// checker for the hold list parser: predicts results from taken bytes and compares them
`timescale 1ns / 1ps

module fhlp_checker import fhlp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fhlp_in_if   in_mon,
  fhlp_out_if  out_mon,
  output int   error_count,
  output int   pending,
  output int   bytes_taken,
  output int   holds_seen,
  output int   status_seen
);

  typedef struct packed {
    logic       kind;
    logic [1:0] cls;
    logic [7:0] number;
    logic [1:0] status;
    logic       last_flag;
  } hold_result_t;

  hold_result_t expected_results[$];
  hold_result_t exp_res;

  // parser state as the byte stream leaves it
  logic [1:0] frame_st;
  logic       start_ph;
  logic [1:0] cur_cls;
  logic [7:0] acc;
  logic       dig_stop;

  int errs;
  int n_bytes;
  int n_holds;
  int n_status;

  function automatic hold_result_t make_result(logic kind, logic [1:0] cls,
                                               logic [7:0] number, logic [1:0] status);
    hold_result_t r;
    r.kind      = kind;
    r.cls       = cls;
    r.number    = number;
    r.status    = status;
    r.last_flag = 1'b0;
    return r;
  endfunction

  task automatic clear_parse();
    start_ph = 1'b0;
    cur_cls  = CLS_START;
    acc      = 8'd0;
    dig_stop = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic empty);
    hold_result_t res[2];
    int n;
    n = 0;
    if (empty) begin
      frame_st = ST_WAIT;
      clear_parse();
      res[0] = make_result(KIND_STATUS, CLS_START, 8'd0, ST_ERR);
      n = 1;
    end else begin
      // a new chunk after a finished message is checked as a start again
      if (first && frame_st == ST_DONE) begin
        frame_st = ST_WAIT;
        clear_parse();
      end
      if (frame_st == ST_WAIT) begin
        if (first) begin
          start_ph = (b == CH_L) && !last;
        end else if (start_ph) begin
          start_ph = 1'b0;
          if (b == CH_HASH) begin
            clear_parse();
            frame_st = ST_DATA;
          end
        end
      end else if (frame_st == ST_DATA) begin
        if (last && b == CH_HASH) begin
          res[n] = make_result(KIND_HOLD, cur_cls, acc, ST_WAIT);
          n++;
          frame_st = ST_DONE;
          clear_parse();
        end else if (b == CH_S) begin
          cur_cls = CLS_START;
        end else if (b == CH_P) begin
          cur_cls = CLS_MOVE;
        end else if (b == CH_E) begin
          cur_cls = CLS_FINISH;
        end else if (b == CH_COMMA) begin
          res[n] = make_result(KIND_HOLD, cur_cls, acc, ST_WAIT);
          n++;
          acc      = 8'd0;
          dig_stop = 1'b0;
        end else if (!dig_stop && b >= CH_ZERO && b <= CH_NINE) begin
          acc = 8'(acc * 10 + (b - CH_ZERO));
        end else begin
          dig_stop = 1'b1;
        end
      end
      if (last) begin
        res[n] = make_result(KIND_STATUS, CLS_START, 8'd0, frame_st);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      res[i].last_flag = (i == n - 1);
      expected_results.push_back(res[i]);
    end
  endtask

  task automatic check_field(input string fname, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_st = ST_WAIT;
      clear_parse();
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        parse_byte(in_mon.data_byte, in_mon.chunk_first, in_mon.chunk_last,
                   in_mon.empty_chunk);
        n_bytes++;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (out_mon.result_kind == KIND_STATUS) n_status++;
        else n_holds++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d class %0d number %0d status %0d",
                 out_mon.result_kind, out_mon.hold_class, out_mon.hold_number,
                 out_mon.chunk_status);
          errs++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("result_kind", exp_res.kind, out_mon.result_kind);
          check_field("hold_class", exp_res.cls, out_mon.hold_class);
          check_field("hold_number", exp_res.number, out_mon.hold_number);
          check_field("chunk_status", exp_res.status, out_mon.chunk_status);
          check_field("last_of_item", exp_res.last_flag, out_mon.last_of_item);
        end
      end
    end
    error_count <= errs;
    pending     <= expected_results.size();
    bytes_taken <= n_bytes;
    holds_seen  <= n_holds;
    status_seen <= n_status;
  end

endmodule

@@ bench/framed_hold_list_parser_tb.sv @@
// testbench top for the hold list parser: byte stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module framed_hold_list_parser_tb import fhlp_pkg::*; ();

  localparam int CYCLE_LIMIT = 600_000;
  localparam int PHASE_ITEMS = 425;

  logic clk;
  logic rst_n;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int bytes_sent;
  int phase_start;

  int error_count;
  int pending;
  int bytes_taken;
  int holds_seen;
  int status_seen;

  fhlp_in_if  in_chan();
  fhlp_out_if out_chan();

  framed_hold_list_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fhlp_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .error_count (error_count),
    .pending     (pending),
    .bytes_taken (bytes_taken),
    .holds_seen  (holds_seen),
    .status_seen (status_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver side: random back-pressure at the current stall rate
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] digit(int d);
    return 8'(CH_ZERO + d);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic empty);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid     <= 1'b0;
      in_chan.data_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.data_byte   <= b;
    in_chan.chunk_first <= first;
    in_chan.chunk_last  <= last;
    in_chan.empty_chunk <= empty;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_chunk(input logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++)
      send_byte(bytes[i], i == 0, i == bytes.size() - 1, 1'b0);
  endtask

  // a well-formed message with random fields, cut into random chunks
  task automatic send_message();
    logic [7:0] msg[$];
    logic [7:0] chunk[$];
    int nfields;
    int ndig;
    int cut;
    msg = {CH_L, CH_HASH};
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) msg.push_back(CH_COMMA);
      case ($urandom_range(3))
        0: msg.push_back(CH_S);
        1: msg.push_back(CH_P);
        2: msg.push_back(CH_E);
        default: ;
      endcase
      if ($urandom_range(7) == 0) msg.push_back(8'($urandom_range(255)));
      // long digit runs make the value wrap
      ndig = ($urandom_range(5) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
      repeat (ndig) msg.push_back(digit($urandom_range(9)));
      if ($urandom_range(5) == 0) begin
        msg.push_back(8'($urandom_range(255)));
        if ($urandom_range(1) == 0) msg.push_back(digit($urandom_range(9)));
      end
    end
    msg.push_back(CH_HASH);
    // a first chunk of exactly two bytes is the start-only case
    cut = ($urandom_range(3) == 0) ? 2 : $urandom_range(2, 8);
    while (msg.size() != 0) begin
      chunk = {};
      repeat (cut) if (msg.size() != 0) chunk.push_back(msg.pop_front());
      send_chunk(chunk);
      cut = $urandom_range(1, 8);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(5))
      0: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
      1: repeat ($urandom_range(1, 6))
           send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'b0);
      2: send_chunk({CH_L, 8'($urandom_range(255)), 8'($urandom_range(255))});
      3: send_byte(CH_L, 1'b1, 1'b1, 1'b0);
      4: begin
        // message broken off by an empty chunk
        send_chunk({CH_L, CH_HASH, CH_P, digit($urandom_range(9))});
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
      end
      default: repeat ($urandom_range(1, 4))
        send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
    endcase
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.data_byte   <= 8'd0;
    in_chan.chunk_first <= 1'b0;
    in_chan.chunk_last  <= 1'b0;
    in_chan.empty_chunk <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      phase_start = bytes_sent;
      if (ph == 0) begin
        send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        send_byte(CH_L, 1'b1, 1'b1, 1'b0);
        send_chunk({CH_L, 8'h00});
        send_chunk({CH_L, CH_HASH});
        // move 12, a field with digits after junk, move 300 wrapped, finish 255
        send_chunk({CH_P, digit(1), digit(2), CH_COMMA, 8'h78, digit(3), CH_COMMA,
                    CH_P, digit(3), digit(0), digit(0), CH_COMMA,
                    CH_E, digit(2), digit(5), digit(5)});
        send_chunk({CH_HASH});
        send_byte(8'h80, 1'b0, 1'b1, 1'b0);
      end
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) send_noise();
        else send_message();
      end
    end

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes through four idle and stall phases", bytes_taken);
    $display("checked %0d hold results and %0d chunk status results", holds_seen, status_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ framed_hold_list_parser.f @@
hdl/fhlp_pkg.sv
hdl/fhlp_in_if.sv
hdl/fhlp_out_if.sv
hdl/fhlp_front.sv
hdl/fhlp_queue.sv
hdl/fhlp_back.sv
hdl/framed_hold_list_parser.sv
bench/fhlp_checker.sv
bench/framed_hold_list_parser_tb.sv
